@@ rtl/core/b32d_pkg.sv @@
package b32d_pkg;

    localparam int CharW  = 8;
    localparam int SymW   = 5;
    localparam int CountW = 13;
    localparam int StatW  = 2;
    localparam int BufW   = 12;
    localparam int HeldW  = 4;

    localparam logic [StatW-1:0] ST_OK       = 2'd0;
    localparam logic [StatW-1:0] ST_BADCHAR  = 2'd1;
    localparam logic [StatW-1:0] ST_CAPACITY = 2'd2;

    localparam logic [CountW-1:0] CapReset = 13'd64;

    localparam logic [CharW-1:0] ChEnd   = 8'h00;
    localparam logic [CharW-1:0] ChPad   = 8'h3D; // '='
    localparam logic [CharW-1:0] ChDash  = 8'h2D; // '-'
    localparam logic [CharW-1:0] ChSpace = 8'h20; // ' '
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
    localparam logic [CharW-1:0] ChLoA   = 8'h61;
    localparam logic [CharW-1:0] ChLoZ   = 8'h7A;
    localparam logic [CharW-1:0] ChTwo   = 8'h32;
    localparam logic [CharW-1:0] ChSeven = 8'h37;
    localparam logic [SymW-1:0]  DigitBase = 5'd26;

    localparam logic [HeldW-1:0] HeldStep = 4'd5;
    localparam logic [HeldW-1:0] ByteBits = 4'd8;

    typedef enum logic [1:0] {
        CLS_SYM,
        CLS_SKIP,
        CLS_BAD,
        CLS_END
    } char_cls_t;

    typedef struct packed {
        char_cls_t       cls;
        logic [SymW-1:0] sym;
    } cls_beat_t;

endpackage

@@ rtl/core/b32d_front.sv @@
module b32d_front (
    input  logic [b32d_pkg::CharW-1:0] char_code,
    output b32d_pkg::cls_beat_t        beat
);
    import b32d_pkg::*;

    logic [CharW-1:0] up_off;
    logic [CharW-1:0] lo_off;
    logic [CharW-1:0] dg_off;

    assign up_off = char_code - ChUpA;
    assign lo_off = char_code - ChLoA;
    assign dg_off = char_code - ChTwo;

    // map one character onto its class and 5-bit symbol value
    always_comb
    begin
        beat.cls = CLS_BAD;
        beat.sym = '0;
        if (char_code == ChEnd)
        begin
            beat.cls = CLS_END;
        end
        else if (char_code == ChPad || char_code == ChDash || char_code == ChSpace)
        begin
            beat.cls = CLS_SKIP;
        end
        else if (char_code >= ChUpA && char_code <= ChUpZ)
        begin
            beat.cls = CLS_SYM;
            beat.sym = up_off[SymW-1:0];
        end
        else if (char_code >= ChLoA && char_code <= ChLoZ)
        begin
            beat.cls = CLS_SYM;
            beat.sym = lo_off[SymW-1:0];
        end
        else if (char_code >= ChTwo && char_code <= ChSeven)
        begin
            beat.cls = CLS_SYM;
            beat.sym = DigitBase + dg_off[SymW-1:0];
        end
    end

endmodule

@@ rtl/core/b32d_queue.sv @@
module b32d_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  b32d_pkg::cls_beat_t push_beat,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b32d_pkg::cls_beat_t pop_beat
);
    import b32d_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    cls_beat_t        slot_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FullCnt);
    assign pop_valid  = (count_reg != '0);
    assign pop_beat   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

`ifndef SYNTHESIS
    // fill level never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue fill level out of range");

    // pointers agree with the fill level when empty
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree while empty");
`endif

endmodule

@@ rtl/core/b32d_back.sv @@
module b32d_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [b32d_pkg::CountW-1:0]  cfg_wr_data,
    input  logic                         beat_valid,
    output logic                         beat_ready,
    input  b32d_pkg::cls_beat_t          beat,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         byte_valid,
    output logic [7:0]                   data_byte,
    output logic                         string_done,
    output logic [b32d_pkg::StatW-1:0]   status,
    output logic [b32d_pkg::CountW-1:0]  byte_count
);
    import b32d_pkg::*;

    logic [CountW-1:0] cap_reg;
    logic [BufW-1:0]   buf_reg, buf_next;
    logic [HeldW-1:0]  held_reg, held_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [StatW-1:0]  err_reg, err_next;

    logic              out_valid_reg;
    logic              bv_reg, bv_next;
    logic [7:0]        data_reg, data_next;
    logic              done_reg, done_next;
    logic [StatW-1:0]  stat_reg, stat_next;
    logic [CountW-1:0] bc_reg, bc_next;

    logic              take;
    logic [BufW-1:0]   shifted;
    logic [BufW-1:0]   aligned;
    logic [HeldW-1:0]  held_add;

    assign beat_ready = !out_valid_reg || out_ready;
    assign take       = beat_valid && beat_ready;
    assign shifted    = {buf_reg[BufW-SymW-1:0], beat.sym};
    assign held_add   = held_reg + HeldStep;
    assign aligned    = shifted >> (held_add - ByteBits);

    always_comb
    begin
        buf_next  = buf_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        bv_next   = 1'b0;
        data_next = '0;
        done_next = 1'b0;
        priority if (beat.cls == CLS_END)
        begin
            done_next = 1'b1;
        end
        else if (err_reg != ST_OK || beat.cls == CLS_SKIP)
        begin
            // latched error or skipped character: state kept
        end
        else if (beat.cls == CLS_BAD)
        begin
            err_next = ST_BADCHAR;
        end
        else
        begin
            buf_next  = shifted;
            held_next = held_add;
            if (held_add >= ByteBits)
            begin
                if (cnt_reg >= cap_reg)
                begin
                    err_next = ST_CAPACITY;
                end
                else
                begin
                    // 8 to 12 bits held: oldest byte sits at offset held-8
                    data_next = aligned[7:0];
                    bv_next   = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    held_next = held_add - ByteBits;
                end
            end
        end
        stat_next = err_next;
        bc_next   = cnt_next;
        if (done_next)
        begin
            buf_next  = '0;
            held_next = '0;
            cnt_next  = '0;
            err_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CapReset;
            buf_reg       <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (take)
            begin
                buf_reg  <= buf_next;
                held_reg <= held_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
            if (beat_ready)
            begin
                out_valid_reg <= beat_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            bv_reg   <= bv_next;
            data_reg <= data_next;
            done_reg <= done_next;
            stat_reg <= stat_next;
            bc_reg   <= bc_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_valid  = bv_reg;
    assign data_byte   = data_reg;
    assign string_done = done_reg;
    assign status      = stat_reg;
    assign byte_count  = bc_reg;

`ifndef SYNTHESIS
    // a byte only comes out while no error is latched
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bv_reg) |-> (stat_reg == ST_OK))
        else $error("byte emitted with error status");

    // end of string never carries a byte
    a_done_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> !bv_reg)
        else $error("end of string beat carries a byte");

    // without an error the buffer never holds a full byte between beats
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == ST_OK) |-> (held_reg < ByteBits))
        else $error("bit buffer overfilled without error");

    // after an end of string beat the string state is clear
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (take && beat.cls == CLS_END) |=> (cnt_reg == '0 && err_reg == ST_OK
                                           && held_reg == '0))
        else $error("string state not cleared");
`endif

endmodule

@@ rtl/core/base32_stream_decoder.sv @@
// base32 stream decoder, one character per input beat
//
// input channel: char_code with in_valid / in_ready. letters of either case
// and digits 2..7 each add five bits; '=', '-' and space are skipped; code 0
// ends the string. every accepted beat gives exactly one output beat.
// output channel: byte_valid, data_byte, string_done, status, byte_count with
// out_valid / out_ready. status 0 ok, 1 bad character, 2 capacity exceeded;
// the first error latches until the end-of-string beat, which reports the
// final status and count and clears the string state.
// config: cfg_wr_en / cfg_wr_data load out_capacity; the user must write it
// only while the block is idle, which the block itself does not enforce.
// path: a taken beat waits in the queue, then the back stage registers it.
// throughput: one beat per cycle while out_ready is high; the classifier, a
// small queue and the bit-buffer stage each take a beat every cycle.
// stall: when out_ready is low the output register holds, the queue fills,
// and in_ready drops once the queue is full.
// reset: out_capacity returns to 64, buffer, count and error clear, both
// queue and output register empty.
module base32_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [b32d_pkg::CountW-1:0]  cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [b32d_pkg::CharW-1:0]   char_code,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         byte_valid,
    output logic [7:0]                   data_byte,
    output logic                         string_done,
    output logic [b32d_pkg::StatW-1:0]   status,
    output logic [b32d_pkg::CountW-1:0]  byte_count
);
    import b32d_pkg::*;

    cls_beat_t front_beat;
    cls_beat_t head_beat;
    logic      head_valid;
    logic      head_ready;

    // front: character classification
    b32d_front u_front (
        .char_code (char_code),
        .beat      (front_beat)
    );

    // decouples classification from the bit-buffer stage
    b32d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_beat  (front_beat),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_beat   (head_beat)
    );

    // back: bit buffer, byte count, error latch and output register
    b32d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .beat_valid  (head_valid),
        .beat_ready  (head_ready),
        .beat        (head_beat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_valid  (byte_valid),
        .data_byte   (data_byte),
        .string_done (string_done),
        .status      (status),
        .byte_count  (byte_count)
    );

endmodule
